### design/quantizing_bit_packer_assert.svh
// quantizing_bit_packer_assert.svh: assertion macros of the quantizing bit packer.
// Expects clk_i and rst_ni in the scope that expands them.
`ifndef QUANTIZING_BIT_PACKER_ASSERT_SVH
`define QUANTIZING_BIT_PACKER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define QBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle leads to another in the next.
`define QBP_ASSERT_NEXT(name, pre, post, msg) \
  `QBP_ASSERT(name, (pre) |=> (post), msg)

`endif

### design/qbp_pkg.sv
// qbp_pkg.sv: constants, codes and types of the quantizing bit packer.
// No dependencies; the interfaces and all modules import it.
`timescale 1ns / 1ps

package qbp_pkg;

  localparam int unsigned STORE_SIZE    = 4096;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned VAL_W         = 64;
  localparam int unsigned QW            = 10;  // widest quantized fraction
  localparam int unsigned REAL_FB       = 8;
  localparam int unsigned PRECISE_FB    = 10;
  localparam int unsigned UNIT_STEP     = 2;   // unit fraction width lost per level
  localparam int unsigned NLEVELS       = 4;

  localparam int unsigned OFF_W       = $clog2(WORD_W);
  localparam int unsigned STORE_WORDS = STORE_SIZE / WORD_W;
  localparam int unsigned ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned POS_W       = $clog2(STORE_SIZE + 1);
  localparam int unsigned FIELD_W     = VAL_W + QW;
  localparam int unsigned WIN_WORDS   = 3;
  localparam int unsigned WIN_W       = WIN_WORDS * WORD_W;
  localparam int unsigned NB_W        = $clog2(FIELD_W + 1);
  localparam int unsigned SPAN_W      = $clog2(WIN_WORDS);
  localparam int unsigned SUM_W       = ((OFF_W > NB_W) ? OFF_W : NB_W) + 1;

  typedef enum logic [3:0] {
    MODE_WR_BOOL    = 4'd0,
    MODE_WR_INT     = 4'd1,
    MODE_WR_UNIT    = 4'd2,
    MODE_WR_REAL    = 4'd3,
    MODE_WR_PRECISE = 4'd4,
    MODE_RD_BOOL    = 4'd5,
    MODE_RD_INT     = 4'd6,
    MODE_RD_UNIT    = 4'd7,
    MODE_RD_REAL    = 4'd8,
    MODE_RD_PRECISE = 4'd9,
    MODE_REWIND_WR  = 4'd10,
    MODE_REWIND_RD  = 4'd11,
    MODE_SEEK       = 4'd12,
    MODE_SKIP       = 4'd13
  } mode_e;

  typedef enum logic [2:0] {
    KIND_BOOL,
    KIND_INT,
    KIND_UNIT,
    KIND_REAL,
    KIND_PRECISE
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIR   = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_MEM,
    S_FIN
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] level;
  } codec_req_t;

endpackage

### design/qbp_if.sv
// qbp_if.sv: valid/ready channels of the quantizing bit packer.
// Depends on qbp_pkg for the field widths.
`timescale 1ns / 1ps

interface qbp_in_if
  import qbp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [3:0]              mode;
  logic [1:0]              level;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, output mode, output level, output value_in, input ready);
  modport sink   (input valid, input mode, input level, input value_in, output ready);
endinterface

interface qbp_out_if
  import qbp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_out;
  logic [1:0]              status;
  logic [POS_W-1:0]        position;
  logic [POS_W-1:0]        used_bits;

  modport source (output valid, output value_out, output status, output position,
                  output used_bits, input ready);
  modport sink   (input valid, input value_out, input status, input position,
                  input used_bits, output ready);
endinterface

### design/qbp_store.sv
// qbp_store.sv: word-wide bit store, one write and one registered read per cycle.
// Depends on qbp_pkg for depth and widths.
`timescale 1ns / 1ps

module qbp_store
  import qbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [STORE_WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/qbp_codec.sv
// qbp_codec.sv: field encoder (saturate, quantize) and decoder (sign-extend, dequantize).
// Depends on qbp_pkg for widths, kinds and the request struct.
`timescale 1ns / 1ps

module qbp_codec
  import qbp_pkg::*;
(
  input  codec_req_t         req_i,
  input  logic [VAL_W-1:0]   value_i,
  input  logic [FIELD_W-1:0] rd_field_i,
  output logic [NB_W-1:0]    nbits_o,
  output logic [FIELD_W-1:0] wr_field_o,
  output logic [VAL_W-1:0]   wr_value_o,
  output logic [VAL_W-1:0]   rd_value_o
);

  // Clamp to the signed range of n bits, keep the low n bits.
  function automatic logic [VAL_W-1:0] sat_to(input logic [VAL_W-1:0] v,
                                              input int unsigned n);
    logic signed [VAL_W-1:0] sv;
    logic signed [VAL_W-1:0] lim_hi;
    logic signed [VAL_W-1:0] lim_lo;
    if (n >= VAL_W) return v;
    sv     = signed'(v);
    lim_hi = (VAL_W'(1) <<< (n - 1)) - VAL_W'(1);
    lim_lo = -(VAL_W'(1) <<< (n - 1));
    if (sv > lim_hi) sv = lim_hi;
    else if (sv < lim_lo) sv = lim_lo;
    return VAL_W'(sv) & ((VAL_W'(1) << n) - VAL_W'(1));
  endfunction

  function automatic logic [VAL_W-1:0] sext_from(input logic [VAL_W-1:0] raw,
                                                 input int unsigned n);
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] r;
    if (n >= VAL_W) return raw;
    mask = (VAL_W'(1) << n) - VAL_W'(1);
    r    = raw & mask;
    if (r[n-1]) r = r | ~mask;
    return r;
  endfunction

  // floor(v * (2^b - 1) / 2^F), clamped to 0 .. 2^b - 1.
  function automatic logic [QW-1:0] quantize(input logic [VAL_W-1:0] u,
                                             input int unsigned b);
    logic [FRACTION_BITS+QW-1:0] t;
    logic [QW-1:0]               m;
    m = QW'((32'd1 << b) - 32'd1);
    t = (FRACTION_BITS+QW)'(u[FRACTION_BITS-1:0]) << b;
    t = t - (FRACTION_BITS+QW)'(u[FRACTION_BITS-1:0]);
    if (u[VAL_W-1]) return '0;
    if (u >= (VAL_W'(1) << FRACTION_BITS)) return m;
    return QW'(t >> FRACTION_BITS);
  endfunction

  // q / (2^b - 1) in Q.F rounded half up: the quotient is q repeated in
  // base 2^b, so take F fraction bits of the repetition and one rounding bit.
  function automatic logic [FRACTION_BITS:0] dequant(input logic [QW-1:0] q,
                                                     input int unsigned b);
    logic [FRACTION_BITS:0] r;
    int unsigned            k;
    k = b - 1;
    r = '0;
    for (int j = FRACTION_BITS; j >= 0; j--) begin
      r[j] = q[k];
      if (k == 0) k = b - 1;
      else k = k - 1;
    end
    return (FRACTION_BITS+1)'(r[FRACTION_BITS:1]) + (FRACTION_BITS+1)'(r[0]);
  endfunction

  logic [VAL_W-1:0]   floor_v;
  logic [QW-1:0]      rq_real;
  logic [QW-1:0]      rq_prec;
  logic [VAL_W-1:0]   dq_real;
  logic [VAL_W-1:0]   dq_prec;
  logic [VAL_W-1:0]   int_raw  [NLEVELS];
  logic [VAL_W-1:0]   int_ext  [NLEVELS];
  logic [VAL_W-1:0]   flr_raw  [NLEVELS];
  logic [VAL_W-1:0]   flr_ext  [NLEVELS];
  logic [QW-1:0]      unit_q   [NLEVELS];
  logic [VAL_W-1:0]   unit_dec [NLEVELS];
  logic [FIELD_W-1:0] real_fld [NLEVELS];
  logic [FIELD_W-1:0] prec_fld [NLEVELS];
  logic [VAL_W-1:0]   rd_int   [NLEVELS];
  logic [VAL_W-1:0]   rd_unit  [NLEVELS];
  logic [QW-1:0]      rd_fq    [NLEVELS];
  logic [VAL_W-1:0]   rd_real  [NLEVELS];
  logic [VAL_W-1:0]   rd_prec  [NLEVELS];

  // Build every level in parallel, then pick by level.
  always_comb begin
    floor_v = VAL_W'(signed'(value_i) >>> FRACTION_BITS);
    rq_real = quantize(VAL_W'(value_i[FRACTION_BITS-1:0]), REAL_FB);
    rq_prec = quantize(VAL_W'(value_i[FRACTION_BITS-1:0]), PRECISE_FB);
    dq_real = VAL_W'(dequant(rq_real, REAL_FB));
    dq_prec = VAL_W'(dequant(rq_prec, PRECISE_FB));
    for (int l = 0; l < NLEVELS; l++) begin
      int_raw[l]  = sat_to(value_i, VAL_W >> l);
      int_ext[l]  = sext_from(int_raw[l], VAL_W >> l);
      flr_raw[l]  = sat_to(floor_v, VAL_W >> l);
      flr_ext[l]  = sext_from(flr_raw[l], VAL_W >> l) << FRACTION_BITS;
      unit_q[l]   = quantize(value_i, QW - UNIT_STEP * l);
      unit_dec[l] = VAL_W'(dequant(unit_q[l], QW - UNIT_STEP * l));
      real_fld[l] = FIELD_W'(flr_raw[l]) | (FIELD_W'(rq_real) << (VAL_W >> l));
      prec_fld[l] = FIELD_W'(flr_raw[l]) | (FIELD_W'(rq_prec) << (VAL_W >> l));
      rd_int[l]   = sext_from(rd_field_i[VAL_W-1:0], VAL_W >> l);
      rd_unit[l]  = VAL_W'(dequant(rd_field_i[QW-1:0], QW - UNIT_STEP * l));
      rd_fq[l]    = QW'(rd_field_i >> (VAL_W >> l));
      rd_real[l]  = (rd_int[l] << FRACTION_BITS) + VAL_W'(dequant(rd_fq[l], REAL_FB));
      rd_prec[l]  = (rd_int[l] << FRACTION_BITS) + VAL_W'(dequant(rd_fq[l], PRECISE_FB));
    end
  end

  always_comb begin
    case (req_i.kind)
      KIND_BOOL: begin
        nbits_o    = NB_W'(1);
        wr_field_o = FIELD_W'(value_i != '0);
        wr_value_o = VAL_W'(value_i != '0);
        rd_value_o = VAL_W'(rd_field_i[0]);
      end
      KIND_INT: begin
        nbits_o    = NB_W'(VAL_W >> req_i.level);
        wr_field_o = FIELD_W'(int_raw[req_i.level]);
        wr_value_o = int_ext[req_i.level];
        rd_value_o = rd_int[req_i.level];
      end
      KIND_UNIT: begin
        nbits_o    = NB_W'(QW - UNIT_STEP * req_i.level);
        wr_field_o = FIELD_W'(unit_q[req_i.level]);
        wr_value_o = unit_dec[req_i.level];
        rd_value_o = rd_unit[req_i.level];
      end
      KIND_REAL: begin
        nbits_o    = NB_W'((VAL_W >> req_i.level) + REAL_FB);
        wr_field_o = real_fld[req_i.level];
        wr_value_o = flr_ext[req_i.level] + dq_real;
        rd_value_o = rd_real[req_i.level];
      end
      KIND_PRECISE: begin
        nbits_o    = NB_W'((VAL_W >> req_i.level) + PRECISE_FB);
        wr_field_o = prec_fld[req_i.level];
        wr_value_o = flr_ext[req_i.level] + dq_prec;
        rd_value_o = rd_prec[req_i.level];
      end
      default: begin
        nbits_o    = '0;
        wr_field_o = '0;
        wr_value_o = '0;
        rd_value_o = '0;
      end
    endcase
  end

endmodule

### design/quantizing_bit_packer.sv
// quantizing_bit_packer.sv: top level; item sequencer around the bit store and codec.
// Depends on qbp_pkg, qbp_if, qbp_store, qbp_codec and quantizing_bit_packer_assert.svh.
`timescale 1ns / 1ps

// Quantizing bit packer. Each input item either packs one field into a
// 4096-bit store at the running bit position (boolean, saturated integer,
// quantized unit fraction, or Q.16 real as integer plus fraction), reads
// one back, or moves the position (rewind, seek, skip). Every item returns
// exactly one result with the decoded value, a status and the position and
// used size after the item. A field access goes through a prepare step,
// then one step per 64-bit store word the field touches (1 to 3) through
// the single store port, a read-modify-write for a write, then a step to
// decode and register the result, and an idle step in which the next item
// is taken. Rewind, seek, skip, unused modes and refused accesses skip the
// store steps. The result register lets a new item in while the previous
// result still waits to be taken. The store needs no clearing after reset:
// only bits below the used size are read.
// Bits outside a written field are kept by a read-modify-write of each word.

`include "quantizing_bit_packer_assert.svh"

module quantizing_bit_packer
  import qbp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  qbp_in_if.sink    in_i,
  qbp_out_if.source out_o
);

  state_e state_q, state_d;

  // Held item.
  logic [3:0]       mode_q;
  logic [1:0]       level_q;
  logic [VAL_W-1:0] val_q;

  // Architectural state.
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] used_q;
  logic             rd_dir_q;

  // Prepared access.
  logic [OFF_W-1:0]  off_q;
  logic [ADDR_W-1:0] base_q;
  logic [SPAN_W-1:0] word_q;
  logic [SPAN_W-1:0] last_q;
  logic [WIN_W-1:0]  wr_win_q;
  logic [WIN_W-1:0]  wr_mask_q;
  logic [WIN_W-1:0]  rd_win_q;
  logic              is_write_q;
  logic              rd_ok_q;
  logic [VAL_W-1:0]  wr_value_q;
  status_e           status_q;

  // Result register.
  logic             out_valid_q;
  logic [VAL_W-1:0] out_value_q;
  status_e          out_status_q;
  logic [POS_W-1:0] out_pos_q;
  logic [POS_W-1:0] out_used_q;

  // Decode of the held item.
  kind_e      kind;
  logic       is_field;
  logic       is_write;
  codec_req_t creq;

  logic [NB_W-1:0]    nbits;
  logic [FIELD_W-1:0] wr_field;
  logic [VAL_W-1:0]   wr_value;
  logic [VAL_W-1:0]   rd_value;

  logic [POS_W:0]   end_pos;
  logic             seek_bad;
  logic [VAL_W:0]   skip_sum;
  logic             skip_bad;
  status_e          prep_status;
  logic [POS_W-1:0] prep_pos;
  logic [POS_W-1:0] prep_used;
  logic             prep_dir;
  logic             prep_go;
  logic [SUM_W-1:0] span_sum;
  logic             out_free;

  // Store port.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  always_comb begin
    case (mode_e'(mode_q))
      MODE_WR_BOOL, MODE_RD_BOOL:       kind = KIND_BOOL;
      MODE_WR_INT, MODE_RD_INT:         kind = KIND_INT;
      MODE_WR_UNIT, MODE_RD_UNIT:       kind = KIND_UNIT;
      MODE_WR_REAL, MODE_RD_REAL:       kind = KIND_REAL;
      MODE_WR_PRECISE, MODE_RD_PRECISE: kind = KIND_PRECISE;
      default:                          kind = KIND_BOOL;
    endcase
  end

  assign is_field   = mode_q inside {[MODE_WR_BOOL:MODE_RD_PRECISE]};
  assign is_write   = mode_q inside {[MODE_WR_BOOL:MODE_WR_PRECISE]};
  assign creq.kind  = kind;
  assign creq.level = level_q;

  qbp_codec u_codec (
    .req_i      (creq),
    .value_i    (val_q),
    .rd_field_i (FIELD_W'(rd_win_q >> off_q)),
    .nbits_o    (nbits),
    .wr_field_o (wr_field),
    .wr_value_o (wr_value),
    .rd_value_o (rd_value)
  );

  qbp_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Range checks and the next position, used size and direction.
  always_comb begin
    end_pos  = (POS_W+1)'(pos_q) + (POS_W+1)'(nbits);
    seek_bad = val_q[VAL_W-1] || (val_q > VAL_W'(used_q));
    skip_sum = {val_q[VAL_W-1], val_q} + (VAL_W+1)'(pos_q);
    skip_bad = skip_sum[VAL_W] || (skip_sum > (VAL_W+1)'(used_q));
    span_sum = SUM_W'(pos_q[OFF_W-1:0]) + SUM_W'(nbits) - SUM_W'(1);

    prep_status = ST_OK;
    prep_pos    = pos_q;
    prep_used   = used_q;
    prep_dir    = rd_dir_q;

    if (is_field) begin
      if (is_write == rd_dir_q) begin
        prep_status = ST_DIR;
      end else if (is_write && (end_pos > (POS_W+1)'(STORE_SIZE))) begin
        prep_status = ST_RANGE;
      end else if (!is_write && (end_pos > (POS_W+1)'(used_q))) begin
        prep_status = ST_RANGE;
      end else begin
        prep_pos = end_pos[POS_W-1:0];
        if (is_write && (end_pos > (POS_W+1)'(used_q))) begin
          prep_used = end_pos[POS_W-1:0];
        end
      end
    end else begin
      case (mode_e'(mode_q))
        MODE_REWIND_WR: begin
          prep_pos = '0;
          prep_dir = 1'b0;
        end
        MODE_REWIND_RD: begin
          prep_pos = '0;
          prep_dir = 1'b1;
        end
        MODE_SEEK: begin
          if (seek_bad) prep_status = ST_RANGE;
          else prep_pos = val_q[POS_W-1:0];
        end
        MODE_SKIP: begin
          if (skip_bad) prep_status = ST_RANGE;
          else prep_pos = skip_sum[POS_W-1:0];
        end
        default: begin
          prep_status = ST_OK;
        end
      endcase
    end

    prep_go = is_field && (prep_status == ST_OK);
  end

  assign out_free = !out_valid_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_PREP;
      S_PREP: state_d = prep_go ? S_MEM : S_FIN;
      S_MEM:  if (word_q == last_q) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and store port.
  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    mem_re     = 1'b0;
    mem_raddr  = base_q + ADDR_W'(word_q) + ADDR_W'(1);
    mem_we     = 1'b0;
    mem_waddr  = base_q + ADDR_W'(word_q);
    mem_wdata  = (mem_rdata & ~wr_mask_q[word_q*WORD_W +: WORD_W])
               | wr_win_q[word_q*WORD_W +: WORD_W];
    case (state_q)
      S_PREP: begin
        // Fetch the first word the field touches.
        mem_re    = prep_go;
        mem_raddr = pos_q[OFF_W +: ADDR_W];
      end
      S_MEM: begin
        // Write back this word on a write, fetch the next one if any.
        mem_re = (word_q != last_q);
        mem_we = is_write_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      used_q      <= '0;
      rd_dir_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_PREP) begin
        pos_q    <= prep_pos;
        used_q   <= prep_used;
        rd_dir_q <= prep_dir;
      end
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        // Hold the item for the whole access.
        mode_q  <= in_i.mode;
        level_q <= in_i.level;
        val_q   <= VAL_W'(in_i.value_in);
      end
      S_PREP: begin
        status_q   <= prep_status;
        is_write_q <= is_write;
        rd_ok_q    <= prep_go && !is_write;
        wr_value_q <= (prep_go && is_write) ? wr_value : '0;
        off_q      <= pos_q[OFF_W-1:0];
        base_q     <= pos_q[OFF_W +: ADDR_W];
        word_q     <= '0;
        last_q     <= SPAN_W'(span_sum >> OFF_W);
        wr_win_q   <= WIN_W'(wr_field) << pos_q[OFF_W-1:0];
        wr_mask_q  <= ((WIN_W'(1) << nbits) - WIN_W'(1)) << pos_q[OFF_W-1:0];
      end
      S_MEM: begin
        // Gather words for a read; advance to the next word.
        if (!is_write_q) begin
          rd_win_q[word_q*WORD_W +: WORD_W] <= mem_rdata;
        end
        word_q <= word_q + SPAN_W'(1);
      end
      S_FIN: begin
        if (out_free) begin
          out_value_q  <= rd_ok_q ? rd_value : wr_value_q;
          out_status_q <= status_q;
          out_pos_q    <= pos_q;
          out_used_q   <= used_q;
        end
      end
      default: begin
        word_q <= '0;
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.position  = out_pos_q;
  assign out_o.used_bits = out_used_q;

  // A result never places the position beyond the used size.
  `QBP_ASSERT(a_pos_within_used, out_o.valid |-> (out_o.position <= out_o.used_bits),
              "position beyond used size")
  // A refused item reports a zero value.
  `QBP_ASSERT(a_refused_zero,
              (out_o.valid && (out_o.status != ST_OK)) |-> (out_o.value_out == '0),
              "refused item with nonzero value")
  // The used size only grows.
  `QBP_ASSERT_NEXT(a_used_grows, 1'b1, used_q >= $past(used_q), "used size shrank")

endmodule

### tb/testbench.sv
// testbench.sv: self-checking testbench of the quantizing bit packer.
// Depends on qbp_pkg, qbp_if and the quantizing_bit_packer top level;
// an internal predictor checks every result of every item.
`timescale 1ns / 1ps

module testbench;
  import qbp_pkg::*;

  localparam int          STALL_LIMIT   = 1000; // quiet cycles before giving up
  localparam int          LONG_HOLD     = 60;   // receiver hold-off under pressure
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          MAX_PRINTED   = 50;
  localparam logic [3:0]  MODE_SPARE_LO = 4'd14;
  localparam logic [3:0]  MODE_SPARE_HI = 4'd15;
  localparam logic [3:0]  READ_OFFSET   = MODE_RD_BOOL - MODE_WR_BOOL;

  typedef struct {
    logic [VAL_W-1:0] value;
    status_e          status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] used;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  qbp_in_if  in_ch ();
  qbp_out_if out_ch ();

  quantizing_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the packer state
  logic [STORE_SIZE-1:0] shadow_bits;
  int                    shadow_pos;
  int                    shadow_used;
  bit                    shadow_reading;

  outcome_t outcomes_due[$];

  bit gaps_on;
  int hold_requests;
  int items_sent;
  int results_checked;
  int mismatches;
  int quiet_cycles;
  int n_stored, n_loaded, n_moves, n_dir_refused, n_range_refused;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] field_mask(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] saturate_to(logic [63:0] u, int n);
    longint      v;
    longint      lim;
    logic [63:0] r;
    if (n >= 64) return u;
    v   = signed'(u);
    lim = longint'(1) << (n - 1);
    if (v > lim - 1) v = lim - 1;
    else if (v < -lim) v = -lim;
    r = v;
    return r & field_mask(n);
  endfunction

  function automatic logic [63:0] widen_signed(logic [63:0] raw, int n);
    logic [63:0] r;
    if (n >= 64) return raw;
    r = raw & field_mask(n);
    if (r[n-1]) r = r | ~field_mask(n);
    return r;
  endfunction

  function automatic logic [63:0] quantize_frac(logic [63:0] u, int n);
    if (u[63]) return '0;
    if (u >= (64'd1 << FRACTION_BITS)) return field_mask(n);
    return (u * field_mask(n)) >> FRACTION_BITS;
  endfunction

  // Code back to Q.16, q/m rounded half up
  function automatic logic [63:0] expand_frac(logic [63:0] q, int n);
    logic [63:0] m;
    m = field_mask(n);
    return (q * (64'd1 << (FRACTION_BITS + 1)) + m) / (m << 1);
  endfunction

  function automatic logic [63:0] floor_whole(logic [63:0] u);
    logic signed [63:0] s;
    s = u;
    return s >>> FRACTION_BITS;
  endfunction

  function automatic logic [63:0] join_real(logic [63:0] raw, logic [63:0] q, int ib, int fb);
    return (widen_signed(raw, ib) << FRACTION_BITS) + expand_frac(q, fb);
  endfunction

  function automatic void store_field(int at, logic [63:0] val, int n);
    for (int i = 0; i < n; i++) shadow_bits[at + i] = val[i];
  endfunction

  function automatic logic [63:0] load_field(int at, int n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = shadow_bits[at + i];
    return r;
  endfunction

  // Apply one item to the shadow state and return the result it must give
  function automatic outcome_t pack_step_outcome(logic [3:0] mode, logic [1:0] level,
                                                 logic [63:0] v);
    outcome_t    o;
    kind_e       kind;
    bit          is_write;
    int          ib, ub, fb, nbits;
    logic [63:0] raw, q;
    longint      hop;
    o.value  = '0;
    o.status = ST_OK;
    ib = WORD_W >> level;
    ub = QW - UNIT_STEP * level;
    if (mode <= MODE_RD_PRECISE) begin
      is_write = mode < MODE_RD_BOOL;
      kind = is_write ? kind_e'(mode - MODE_WR_BOOL) : kind_e'(mode - MODE_RD_BOOL);
      fb = (kind == KIND_REAL) ? REAL_FB : PRECISE_FB;
      case (kind)
        KIND_BOOL: nbits = 1;
        KIND_INT:  nbits = ib;
        KIND_UNIT: nbits = ub;
        default:   nbits = ib + fb;
      endcase
      if (is_write == shadow_reading) begin
        o.status = ST_DIR;
      end else if (is_write && shadow_pos + nbits > STORE_SIZE) begin
        o.status = ST_RANGE;
      end else if (!is_write && shadow_pos + nbits > shadow_used) begin
        o.status = ST_RANGE;
      end else if (is_write) begin
        case (kind)
          KIND_BOOL: begin
            raw = (v != 0);
            store_field(shadow_pos, raw, 1);
            o.value = raw;
          end
          KIND_INT: begin
            raw = saturate_to(v, ib);
            store_field(shadow_pos, raw, ib);
            o.value = widen_signed(raw, ib);
          end
          KIND_UNIT: begin
            q = quantize_frac(v, ub);
            store_field(shadow_pos, q, ub);
            o.value = expand_frac(q, ub);
          end
          default: begin
            raw = saturate_to(floor_whole(v), ib);
            q   = quantize_frac(v & field_mask(FRACTION_BITS), fb);
            store_field(shadow_pos, raw, ib);
            store_field(shadow_pos + ib, q, fb);
            o.value = join_real(raw, q, ib, fb);
          end
        endcase
        shadow_pos += nbits;
        if (shadow_pos > shadow_used) shadow_used = shadow_pos;
      end else begin
        case (kind)
          KIND_BOOL: o.value = load_field(shadow_pos, 1);
          KIND_INT:  o.value = widen_signed(load_field(shadow_pos, ib), ib);
          KIND_UNIT: o.value = expand_frac(load_field(shadow_pos, ub), ub);
          default:   o.value = join_real(load_field(shadow_pos, ib),
                                         load_field(shadow_pos + ib, fb), ib, fb);
        endcase
        shadow_pos += nbits;
      end
    end else if (mode == MODE_REWIND_WR || mode == MODE_REWIND_RD) begin
      shadow_pos     = 0;
      shadow_reading = (mode == MODE_REWIND_RD);
    end else if (mode == MODE_SEEK) begin
      if (v[63] || v > shadow_used) o.status = ST_RANGE;
      else shadow_pos = int'(v);
    end else if (mode == MODE_SKIP) begin
      hop = signed'(v);
      if (hop < -longint'(shadow_pos) || hop > longint'(shadow_used) - longint'(shadow_pos))
        o.status = ST_RANGE;
      else
        shadow_pos = shadow_pos + int'(hop);
    end
    o.position = POS_W'(shadow_pos);
    o.used     = POS_W'(shadow_used);
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [63:0] random_operand();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return r;
      1: return 64'(longint'($urandom_range(0, 600)) - 300);
      2: return 64'($urandom_range(0, 65536));
      3: case ($urandom_range(0, 5))
           0:       return 64'h7FFF_FFFF_FFFF_FFFF;
           1:       return 64'h8000_0000_0000_0000;
           2:       return '0;
           3:       return '1;
           4:       return 64'd65536;
           default: return 64'd65535;
         endcase
      4: return {{32{r[31]}}, r[31:0]};
      5: return {{48{r[15]}}, r[15:0]};
      6: return {{40{r[23]}}, r[23:0]};
      default: return r >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", what);
  endtask

  // Offer one item, hold it until accepted, then record what it must produce
  task automatic send_item(logic [3:0] mode, logic [1:0] level, logic [63:0] value);
    outcome_t want;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.level    <= level;
    in_ch.value_in <= value;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    want = pack_step_outcome(mode, level, value);
    outcomes_due.push_back(want);
    items_sent++;
    if (want.status == ST_DIR) n_dir_refused++;
    else if (want.status == ST_RANGE) n_range_refused++;
    else if (mode <= MODE_WR_PRECISE) n_stored++;
    else if (mode <= MODE_RD_PRECISE) n_loaded++;
    else n_moves++;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outcomes_due.size() != 0);
  endtask

  task automatic send_noise_item();
    logic [3:0]  mode;
    logic [63:0] v;
    mode = $urandom_range(0, 15);
    v    = random_operand();
    if ((mode == MODE_SEEK || mode == MODE_SKIP) && $urandom_range(0, 1) == 1) begin
      v = 64'($urandom_range(0, shadow_used + 8));
      if (mode == MODE_SKIP) v = v - 64'(shadow_pos);
    end
    send_item(mode, $urandom_range(0, 3), v);
  endtask

  // Boundaries, every operation and every refusal, then read the fields back
  task automatic test_directed_cases();
    gaps_on = 1'b1;
    send_item(MODE_RD_BOOL, 2'd0, '0);                   // empty store: past used size
    send_item(MODE_WR_INT, 2'd0, 64'd5);                  // still reading: wrong direction
    send_item(MODE_REWIND_WR, 2'd0, '0);
    send_item(MODE_WR_BOOL, 2'd1, 64'h8000_0000_0000_0000); // any nonzero stores a one
    send_item(MODE_WR_INT, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(MODE_WR_INT, 2'd3, -64'sd1000);              // saturates low
    send_item(MODE_WR_UNIT, 2'd0, 64'd65536);              // full scale
    send_item(MODE_WR_UNIT, 2'd3, -64'sd5);                // negative clamps to zero
    send_item(MODE_WR_REAL, 2'd2, -64'sd229376);           // -3.5
    send_item(MODE_WR_PRECISE, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(MODE_WR_REAL, 2'd3, 64'd300 << FRACTION_BITS); // integer part saturates
    send_item(MODE_RD_INT, 2'd2, '0);                     // writing: wrong direction
    send_item(MODE_SEEK, 2'd0, '1);                       // negative target
    send_item(MODE_SEEK, 2'd0, 64'(shadow_used + 1));     // one past used size
    send_item(MODE_SKIP, 2'd0, 64'(-(longint'(shadow_pos) + 1)));
    send_item(MODE_REWIND_RD, 2'd3, '0);
    send_item(MODE_SKIP, 2'd0, 64'd1);                    // hop over the boolean
    send_item(MODE_RD_INT, 2'd0, '0);
    send_item(MODE_RD_INT, 2'd3, '0);
    send_item(MODE_RD_UNIT, 2'd0, '0);
    send_item(MODE_RD_UNIT, 2'd3, '0);
    send_item(MODE_RD_REAL, 2'd2, '0);
    send_item(MODE_RD_PRECISE, 2'd0, '0);
    send_item(MODE_RD_REAL, 2'd3, '0);
    send_item(MODE_SPARE_LO, 2'd1, '1);
    send_item(MODE_SPARE_HI, 2'd2, 64'd7);
  endtask

  // Fill the store to the last bit, overflow it, and read every word back
  task automatic test_fill_store();
    gaps_on = 1'b1;
    send_item(MODE_REWIND_WR, 2'd0, '0);
    repeat (STORE_WORDS) send_item(MODE_WR_INT, 2'd0, random_operand());
    send_item(MODE_WR_BOOL, 2'd0, 64'd1);
    send_item(MODE_SEEK, 2'd0, 64'(STORE_SIZE - (QW - 2 * UNIT_STEP)));
    send_item(MODE_WR_INT, 2'd3, random_operand());      // 8 bits do not fit
    send_item(MODE_WR_UNIT, 2'd2, random_operand());     // 6 bits end at the top
    send_item(MODE_REWIND_RD, 2'd0, '0);
    repeat (STORE_WORDS) send_item(MODE_RD_INT, 2'd0, random_operand());
    send_item(MODE_RD_BOOL, 2'd0, '0);
    send_item(MODE_SKIP, 2'd0, 64'd1);
    send_item(MODE_SKIP, 2'd0, 64'(-longint'(STORE_SIZE)));
    send_item(MODE_SEEK, 2'd0, 64'(STORE_SIZE));
  endtask

  // Receiver holds off while items keep coming, so the input must stall
  task automatic test_output_stall();
    gaps_on = 1'b0;
    hold_requests++;
    send_item(MODE_REWIND_WR, 2'd1, '0);
    repeat (12) send_item(MODE_WR_INT, $urandom_range(0, 3), random_operand());
  endtask

  // Mostly write-then-read-back runs with random content, some noise between
  task automatic run_random_sequences(int target, bit allow_gaps);
    logic [3:0] kinds_written[$];
    logic [1:0] levels_written[$];
    int         start;
    while (items_sent < target) begin
      gaps_on = allow_gaps && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_noise_item();
      end else begin
        start = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, shadow_used);
        kinds_written.delete();
        levels_written.delete();
        send_item(MODE_REWIND_WR, $urandom_range(0, 3), random_operand());
        if (start != 0) send_item(MODE_SEEK, $urandom_range(0, 3), 64'(start));
        repeat ($urandom_range(1, 16)) begin
          kinds_written.push_back($urandom_range(MODE_WR_BOOL, MODE_WR_PRECISE));
          levels_written.push_back($urandom_range(0, 3));
          send_item(kinds_written[$], levels_written[$], random_operand());
        end
        send_item(MODE_REWIND_RD, $urandom_range(0, 3), random_operand());
        if (start != 0) begin
          if ($urandom_range(0, 1) == 0) send_item(MODE_SEEK, $urandom_range(0, 3), 64'(start));
          else send_item(MODE_SKIP, $urandom_range(0, 3), 64'(start));
        end
        foreach (kinds_written[i]) begin
          if ($urandom_range(0, 11) == 0)
            send_item($urandom_range(MODE_RD_BOOL, MODE_RD_PRECISE), $urandom_range(0, 3),
                      random_operand());
          else
            send_item(kinds_written[i] + READ_OFFSET, levels_written[i], random_operand());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin : receiver
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing pending", results_checked));
      end else begin
        want = outcomes_due.pop_front();
        if (out_ch.value_out !== want.value)
          flag_mismatch($sformatf("result %0d: value %h, expected %h", results_checked,
                                  out_ch.value_out, want.value));
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("result %0d: status %0d, expected %0d", results_checked,
                                  out_ch.status, want.status));
        if (out_ch.position !== want.position)
          flag_mismatch($sformatf("result %0d: position %0d, expected %0d", results_checked,
                                  out_ch.position, want.position));
        if (out_ch.used_bits !== want.used)
          flag_mismatch($sformatf("result %0d: used_bits %0d, expected %0d", results_checked,
                                  out_ch.used_bits, want.used));
      end
      results_checked++;
    end
  end

  // Give up when neither side has moved an item for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("[quantizing_bit_packer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.level    = '0;
    in_ch.value_in = '0;
    shadow_bits    = '0;
    shadow_pos     = 0;
    shadow_used    = 0;
    shadow_reading = 1'b1;
    gaps_on        = 1'b0;
    hold_requests  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    wait_for_results();
    test_fill_store();
    wait_for_results();
    test_output_stall();
    wait_for_results();
    run_random_sequences(1100, 1'b1);
    run_random_sequences(items_sent + 150, 1'b0);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (outcomes_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
    $display("Covered %0d items: %0d fields stored, %0d read back, %0d position moves,",
             items_sent, n_stored, n_loaded, n_moves);
    $display("  %0d refused for direction, %0d refused for range; %0d mismatches.",
             n_dir_refused, n_range_refused, mismatches);
    if (mismatches == 0) begin
      $display("[quantizing_bit_packer] OK");
    end else begin
      $display("[quantizing_bit_packer] ERROR");
    end
    $finish;
  end

endmodule
